// ----- hdl/tpmc_pkg.sv -----
// Shared constants, types and command codes for the two-point moisture calibration block.
package tpmc_pkg;

   localparam int NUM_CHANNELS = 8;
   localparam int SAMPLE_BITS  = 10;
   localparam int CHAN_BITS    = 3;
   localparam int PCT_BITS     = 7;
   localparam int VALUE_BITS   = 10;
   localparam int CMD_BITS     = 2;

   localparam int ADDR_BITS  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int DIFF_BITS  = SAMPLE_BITS + 1;
   localparam int PDIFF_BITS = PCT_BITS + 1;
   localparam int PROD_BITS  = DIFF_BITS + PDIFF_BITS;
   localparam int MAG_BITS   = SAMPLE_BITS + PCT_BITS;
   localparam int CNT_BITS   = $clog2(MAG_BITS + 1);
   localparam int SUM_BITS   = MAG_BITS + 2;

   localparam int REQ_FIELD_BITS = CHAN_BITS + SAMPLE_BITS + PCT_BITS;
   localparam int REQ_DATA_BITS  = ((REQ_FIELD_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_BITS  = ((VALUE_BITS + 7) / 8) * 8;

   localparam int PCT_MAX   = 100;
   localparam int DRY_RESET = 580;
   localparam int WET_RESET = 200;

   typedef enum logic [CMD_BITS-1:0] {
      CMD_CALIBRATE = 2'd0,
      CMD_RAW       = 2'd1,
      CMD_SET_DRY   = 2'd2,
      CMD_SET_WET   = 2'd3
   } cmd_type;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] raw;
      logic [PCT_BITS-1:0]    pct;
   } point_type;

endpackage

// ----- hdl/two_point_moisture_calibration.sv -----
// Top level: per-channel two-point calibration of moisture samples with dry/wet point memories.
// Calibrated measure: read, start, divide (bit-serial span divider) and output states.
// Raw measure, set commands and calibrations with an error status: read and output states.
// One request at a time; req_tready returns as the output state loads the response register
// and raises rsp_tvalid, a step that waits while an earlier response is still unaccepted.
// Synchronous reset clears control and the point valid bits; unwritten points read 580/200/0/100.
module two_point_moisture_calibration
   import tpmc_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [REQ_DATA_BITS-1:0] req_tdata,  // channel, sample, ref_percent
   input  logic [CMD_BITS-1:0]      req_tuser,  // command
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,  // value
   output logic                     rsp_tuser   // status
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_START,
      ST_DIV,
      ST_OUT
   } state_type;

   state_type state_ff;

   logic                   accept;
   cmd_type                req_cmd;
   logic [CHAN_BITS-1:0]   req_chan;
   logic [SAMPLE_BITS-1:0] req_sample;
   logic [PCT_BITS-1:0]    req_pct;
   logic [ADDR_BITS-1:0]   req_addr;
   logic                   req_chan_ok;
   logic                   dry_we;
   logic                   wet_we;

   point_type dry_mem [NUM_CHANNELS];
   point_type wet_mem [NUM_CHANNELS];
   logic [NUM_CHANNELS-1:0] dry_vld_ff;
   logic [NUM_CHANNELS-1:0] wet_vld_ff;
   point_type rd_dry_ff;
   point_type rd_wet_ff;
   logic      rd_dry_vld_ff;
   logic      rd_wet_vld_ff;

   cmd_type                cmd_ff;
   logic                   chan_ok_ff;
   logic [SAMPLE_BITS-1:0] sample_ff;

   point_type                    dry_pt;
   point_type                    wet_pt;
   logic signed [DIFF_BITS-1:0]  span_in;
   logic signed [DIFF_BITS-1:0]  diff_in;
   logic signed [PDIFF_BITS-1:0] pdiff_in;
   logic signed [PROD_BITS-1:0]  prod_in;
   logic signed [PROD_BITS-1:0]  prod_ff;
   logic signed [DIFF_BITS-1:0]  span_ff;
   logic [PCT_BITS-1:0]          pw_ff;
   logic                         neg_ff;

   logic                         div_start;
   logic                         div_done;
   logic [MAG_BITS-1:0]          div_dividend;
   logic [SAMPLE_BITS-1:0]       div_divisor;
   logic [MAG_BITS-1:0]          div_quotient;

   logic signed [SUM_BITS-1:0]   quot_ext;
   logic signed [SUM_BITS-1:0]   quot_sgn;
   logic signed [SUM_BITS-1:0]   sum_in;
   logic [VALUE_BITS-1:0]        cal_value_in;

   logic [VALUE_BITS-1:0] res_value_ff;
   logic                  res_status_ff;
   logic                  rsp_tvalid_ff;
   logic [VALUE_BITS-1:0] rsp_value_ff;
   logic                  rsp_status_ff;

   assign req_tready  = (state_ff == ST_IDLE);
   assign accept      = req_tvalid && req_tready;
   assign req_cmd     = cmd_type'(req_tuser);
   assign req_chan    = req_tdata[CHAN_BITS-1:0];
   assign req_sample  = req_tdata[CHAN_BITS +: SAMPLE_BITS];
   assign req_pct     = req_tdata[CHAN_BITS + SAMPLE_BITS +: PCT_BITS];
   assign req_addr    = ADDR_BITS'(req_chan);
   assign req_chan_ok = int'(req_chan) < NUM_CHANNELS;
   assign dry_we      = accept && (req_cmd == CMD_SET_DRY) && req_chan_ok;
   assign wet_we      = accept && (req_cmd == CMD_SET_WET) && req_chan_ok;

   always_ff @(posedge clock) begin
      if (dry_we) begin
         dry_mem[req_addr] <= '{raw: req_sample, pct: req_pct};
      end
      if (wet_we) begin
         wet_mem[req_addr] <= '{raw: req_sample, pct: req_pct};
      end
      if (accept) begin
         rd_dry_ff     <= dry_mem[req_addr];
         rd_wet_ff     <= wet_mem[req_addr];
         rd_dry_vld_ff <= dry_vld_ff[req_addr];
         rd_wet_vld_ff <= wet_vld_ff[req_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dry_vld_ff <= '0;
         wet_vld_ff <= '0;
      end else begin
         if (dry_we) begin
            dry_vld_ff[req_addr] <= 1'b1;
         end
         if (wet_we) begin
            wet_vld_ff[req_addr] <= 1'b1;
         end
      end
   end

   assign dry_pt = rd_dry_vld_ff ? rd_dry_ff
                 : '{raw: SAMPLE_BITS'(DRY_RESET), pct: PCT_BITS'(0)};
   assign wet_pt = rd_wet_vld_ff ? rd_wet_ff
                 : '{raw: SAMPLE_BITS'(WET_RESET), pct: PCT_BITS'(PCT_MAX)};

   assign span_in  = $signed({1'b0, dry_pt.raw}) - $signed({1'b0, wet_pt.raw});
   assign diff_in  = $signed({1'b0, sample_ff}) - $signed({1'b0, wet_pt.raw});
   assign pdiff_in = $signed({1'b0, dry_pt.pct}) - $signed({1'b0, wet_pt.pct});
   assign prod_in  = PROD_BITS'(diff_in) * PROD_BITS'(pdiff_in);

   assign div_start    = (state_ff == ST_START);
   assign div_dividend = prod_ff[PROD_BITS-1] ? MAG_BITS'(-prod_ff) : MAG_BITS'(prod_ff);
   assign div_divisor  = span_ff[DIFF_BITS-1] ? SAMPLE_BITS'(-span_ff) : SAMPLE_BITS'(span_ff);

   tpmc_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign quot_ext = $signed({2'b00, div_quotient});
   assign quot_sgn = neg_ff ? -quot_ext : quot_ext;
   assign sum_in   = quot_sgn + $signed({{(SUM_BITS - PCT_BITS){1'b0}}, pw_ff});

   always_comb begin
      if (sum_in[SUM_BITS-1]) begin
         cal_value_in = '0;
      end else if (sum_in > SUM_BITS'(PCT_MAX)) begin
         cal_value_in = VALUE_BITS'(PCT_MAX);
      end else begin
         cal_value_in = VALUE_BITS'(sum_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         if (rsp_tvalid_ff && rsp_tready && (state_ff != ST_OUT)) begin
            rsp_tvalid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  cmd_ff     <= req_cmd;
                  chan_ok_ff <= req_chan_ok;
                  sample_ff  <= req_sample;
                  state_ff   <= ST_READ;
               end
            end
            ST_READ: begin
               prod_ff <= prod_in;
               span_ff <= span_in;
               pw_ff   <= wet_pt.pct;
               case (cmd_ff)
                  CMD_CALIBRATE: begin
                     res_value_ff <= '0;
                     if (!chan_ok_ff || (span_in == '0)) begin
                        res_status_ff <= 1'b1;
                        state_ff      <= ST_OUT;
                     end else begin
                        res_status_ff <= 1'b0;
                        state_ff      <= ST_START;
                     end
                  end
                  CMD_RAW: begin
                     res_value_ff  <= VALUE_BITS'(sample_ff);
                     res_status_ff <= 1'b0;
                     state_ff      <= ST_OUT;
                  end
                  default: begin
                     res_value_ff  <= VALUE_BITS'(sample_ff);
                     res_status_ff <= !chan_ok_ff;
                     state_ff      <= ST_OUT;
                  end
               endcase
            end
            ST_START: begin
               neg_ff   <= prod_ff[PROD_BITS-1] ^ span_ff[DIFF_BITS-1];
               state_ff <= ST_DIV;
            end
            ST_DIV: begin
               if (div_done) begin
                  res_value_ff <= cal_value_in;
                  state_ff     <= ST_OUT;
               end
            end
            ST_OUT: begin
               if (!rsp_tvalid_ff || rsp_tready) begin
                  rsp_tvalid_ff <= 1'b1;
                  rsp_value_ff  <= res_value_ff;
                  rsp_status_ff <= res_status_ff;
                  state_ff      <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = RSP_DATA_BITS'(rsp_value_ff);
   assign rsp_tuser  = rsp_status_ff;

   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIV))
      else $error("divider finished outside the divide state");

   a_one_request: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_tready)
      else $error("request accepted while another is in flight");

   a_pct_range: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_OUT) && (cmd_ff == CMD_CALIBRATE)) |-> (res_value_ff <= PCT_MAX))
      else $error("calibrated value outside the percent range");

endmodule

// ----- hdl/tpmc_divider.sv -----
// Restoring divider, one quotient bit per cycle, for the calibration span division.
module tpmc_divider
   import tpmc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [MAG_BITS-1:0]    dividend,
   input  logic [SAMPLE_BITS-1:0] divisor,
   output logic                   done,
   output logic [MAG_BITS-1:0]    quotient
);

   logic                   busy_ff;
   logic                   done_ff;
   logic [CNT_BITS-1:0]    cnt_ff;
   logic [SAMPLE_BITS-1:0] rem_ff;
   logic [SAMPLE_BITS-1:0] rem_in;
   logic [MAG_BITS-1:0]    quo_ff;
   logic [MAG_BITS-1:0]    quo_in;
   logic [SAMPLE_BITS-1:0] div_ff;
   logic [SAMPLE_BITS:0]   trial;
   logic                   fits;
   logic                   last_step;

   assign trial     = {rem_ff, quo_ff[MAG_BITS-1]};
   assign fits      = trial >= {1'b0, div_ff};
   assign rem_in    = fits ? SAMPLE_BITS'(trial - {1'b0, div_ff}) : SAMPLE_BITS'(trial);
   assign quo_in    = {quo_ff[MAG_BITS-2:0], fits};
   assign last_step = busy_ff && (cnt_ff == CNT_BITS'(1));

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= last_step;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (last_step) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         div_ff <= divisor;
         cnt_ff <= CNT_BITS'(MAG_BITS);
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
         cnt_ff <= cnt_ff - CNT_BITS'(1);
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ----- tb/moisture_calibration_checker.sv -----
// Checker for the moisture calibration block: predicts each response and compares it.
module moisture_calibration_checker
   import tpmc_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   input  logic                     req_tready,
   input  logic [REQ_DATA_BITS-1:0] req_tdata,  // channel, sample, ref_percent
   input  logic [CMD_BITS-1:0]      req_tuser,  // command
   input  logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   input  logic [RSP_DATA_BITS-1:0] rsp_tdata,  // value
   input  logic                     rsp_tuser,  // status
   output int                       fail_count,
   output int                       pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [VALUE_BITS-1:0] value;
      logic                  status;
   } cal_reading_type;

   logic [SAMPLE_BITS-1:0] dry_raw [NUM_CHANNELS];
   logic [SAMPLE_BITS-1:0] wet_raw [NUM_CHANNELS];
   logic [PCT_BITS-1:0]    dry_pct [NUM_CHANNELS];
   logic [PCT_BITS-1:0]    wet_pct [NUM_CHANNELS];
   cal_reading_type        expected_readings[$];
   int                     response_index;

   initial begin
      fail_count = 0;
      pending = 0;
      response_index = 0;
   end

   task automatic report_mismatch(input string what, input int expected_val, input int got_val);
      $display("[%0t] response %0d: %s expected %0d got %0d", $realtime, response_index, what,
               expected_val, got_val);
      fail_count = fail_count + 1;
   endtask

   // Apply one request to the calibration store and return the reading it should produce.
   function automatic cal_reading_type apply_request(input cmd_type cmd,
                                                     input logic [CHAN_BITS-1:0] ch,
                                                     input logic [SAMPLE_BITS-1:0] smp,
                                                     input logic [PCT_BITS-1:0] pct);
      cal_reading_type rd;
      int              span;
      int              offset;
      int              pct_delta;
      int              pct_result;
      rd.value = smp;
      rd.status = 1'b0;
      case (cmd)
         CMD_CALIBRATE: begin
            span = int'(dry_raw[ch]) - int'(wet_raw[ch]);
            if (span == 0) begin
               rd.value = '0;
               rd.status = 1'b1;
            end else begin
               offset = int'(smp) - int'(wet_raw[ch]);
               pct_delta = int'(dry_pct[ch]) - int'(wet_pct[ch]);
               pct_result = (offset * pct_delta) / span + int'(wet_pct[ch]);
               if (pct_result < 0) pct_result = 0;
               if (pct_result > PCT_MAX) pct_result = PCT_MAX;
               rd.value = pct_result[VALUE_BITS-1:0];
            end
         end
         CMD_SET_DRY: begin
            dry_raw[ch] = smp;
            dry_pct[ch] = pct;
         end
         CMD_SET_WET: begin
            wet_raw[ch] = smp;
            wet_pct[ch] = pct;
         end
         default: ;
      endcase
      return rd;
   endfunction

   always @(posedge clock) begin
      cal_reading_type exp_rd;
      if (reset) begin
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            dry_raw[i] = SAMPLE_BITS'(DRY_RESET);
            wet_raw[i] = SAMPLE_BITS'(WET_RESET);
            dry_pct[i] = '0;
            wet_pct[i] = PCT_BITS'(PCT_MAX);
         end
         expected_readings.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_readings.size() == 0) begin
               report_mismatch("unexpected response, value", -1, int'(rsp_tdata[VALUE_BITS-1:0]));
            end else begin
               exp_rd = expected_readings.pop_front();
               if (rsp_tdata[VALUE_BITS-1:0] !== exp_rd.value)
                  report_mismatch("value", int'(exp_rd.value), int'(rsp_tdata[VALUE_BITS-1:0]));
               if (rsp_tuser !== exp_rd.status)
                  report_mismatch("status", int'(exp_rd.status), int'(rsp_tuser));
            end
            response_index = response_index + 1;
         end
         if (req_tvalid && req_tready) begin
            expected_readings.push_back(apply_request(
               cmd_type'(req_tuser),
               req_tdata[CHAN_BITS-1:0],
               req_tdata[CHAN_BITS +: SAMPLE_BITS],
               req_tdata[CHAN_BITS+SAMPLE_BITS +: PCT_BITS]));
         end
      end
      pending <= expected_readings.size();
   end

endmodule

// ----- tb/tb_top.sv -----
// Testbench top: clock, reset, request and response traffic, watchdog and verdict.
module tb_top;
   import tpmc_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS = 1430;
   localparam int STALL_LIMIT  = 3000;
   localparam int HOLD_START   = 2500;
   localparam int HOLD_CYCLES  = 400;

   logic                     clock;
   logic                     reset;
   logic                     req_tvalid;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata;  // channel, sample, ref_percent
   logic [CMD_BITS-1:0]      req_tuser;  // command
   logic                     rsp_tvalid;
   logic                     rsp_tready;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;  // value
   logic                     rsp_tuser;  // status
   int                       fail_count;
   int                       pending;

   two_point_moisture_calibration DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   moisture_calibration_checker checker_inst (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Offer one request and hold it until accepted; return at the following falling edge.
   task automatic send_request(input cmd_type cmd, input logic [CHAN_BITS-1:0] ch,
                               input logic [SAMPLE_BITS-1:0] smp,
                               input logic [PCT_BITS-1:0] pct);
      req_tuser = cmd;
      req_tdata = '0;
      req_tdata[CHAN_BITS-1:0] = ch;
      req_tdata[CHAN_BITS +: SAMPLE_BITS] = smp;
      req_tdata[CHAN_BITS+SAMPLE_BITS +: PCT_BITS] = pct;
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // Drop valid and wait until every outstanding response has arrived.
   task automatic drain_responses();
      req_tvalid = 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   initial begin
      int      stalls;
      stalls = 0;
      forever begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            stalls = 0;
         else
            stalls = stalls + 1;
         if (stalls >= STALL_LIMIT) begin
            $display("two_point_moisture_calibration verification failed");
            $finish;
         end
      end
   end

   initial begin
      int mode;
      int run;
      int elapsed;
      bit held;
      rsp_tready = 1'b0;
      elapsed = 0;
      held = 1'b0;
      forever begin
         mode = $urandom_range(0, 3);
         run = $urandom_range(10, 80);
         for (int i = 0; i < run; i++) begin
            @(negedge clock);
            if (!reset) elapsed = elapsed + 1;
            if (!held && elapsed >= HOLD_START) begin
               rsp_tready = 1'b0;
               repeat (HOLD_CYCLES) @(negedge clock);
               held = 1'b1;
            end
            case (mode)
               0: rsp_tready = 1'b1;
               1: rsp_tready = ($urandom_range(0, 1) == 0);
               2: rsp_tready = ($urandom_range(0, 7) == 0);
               default: rsp_tready = ($urandom_range(0, 7) != 0);
            endcase
         end
      end
   end

   initial begin
      cmd_type                cmd;
      logic [CHAN_BITS-1:0]   ch;
      logic [SAMPLE_BITS-1:0] smp;
      logic [PCT_BITS-1:0]    pct;
      int                     sent;
      int                     burst;
      int                     gap;
      int                     pick;
      bit                     paused;

      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = CMD_CALIBRATE;
      reset = 1'b1;
      repeat (7) @(negedge clock);
      reset = 1'b0;

      // reset points: clamp high, clamp low, midpoint
      send_request(CMD_CALIBRATE, 3'd0, 10'd0, 7'd0);
      send_request(CMD_CALIBRATE, 3'd7, 10'd1023, 7'd127);
      send_request(CMD_CALIBRATE, 3'd1, 10'd390, 7'd0);
      send_request(CMD_RAW, 3'd2, 10'd1023, 7'd127);
      send_request(CMD_RAW, 3'd5, 10'd0, 7'd0);
      send_request(CMD_RAW, 3'd0, 10'h2AA, 7'h55);
      send_request(CMD_RAW, 3'd1, 10'h155, 7'h2A);
      // full-scale span with out-of-range percent
      send_request(CMD_SET_DRY, 3'd3, 10'd1023, 7'd127);
      send_request(CMD_SET_WET, 3'd3, 10'd0, 7'd0);
      send_request(CMD_CALIBRATE, 3'd3, 10'd512, 7'd0);
      send_request(CMD_CALIBRATE, 3'd3, 10'd1023, 7'd0);
      // zero span
      send_request(CMD_SET_WET, 3'd4, 10'd580, 7'd42);
      send_request(CMD_CALIBRATE, 3'd4, 10'd300, 7'd0);
      // inverted span, negative truncation
      send_request(CMD_SET_DRY, 3'd5, 10'd100, 7'd90);
      send_request(CMD_SET_WET, 3'd5, 10'd900, 7'd10);
      send_request(CMD_CALIBRATE, 3'd5, 10'd50, 7'd0);
      send_request(CMD_CALIBRATE, 3'd5, 10'd905, 7'd0);
      send_request(CMD_CALIBRATE, 3'd5, 10'd1000, 7'd0);
      // equal percents above the clamp and at the clamp
      send_request(CMD_SET_DRY, 3'd6, 10'd1023, 7'd127);
      send_request(CMD_SET_WET, 3'd6, 10'd0, 7'd127);
      send_request(CMD_CALIBRATE, 3'd6, 10'd700, 7'd0);
      send_request(CMD_SET_DRY, 3'd7, 10'd0, 7'd100);
      send_request(CMD_CALIBRATE, 3'd7, 10'd100, 7'd0);
      drain_responses();

      sent = 0;
      paused = 1'b0;
      while (sent < RANDOM_ITEMS) begin
         burst = $urandom_range(1, 24);
         for (int i = 0; i < burst && sent < RANDOM_ITEMS; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 50)      cmd = CMD_CALIBRATE;
            else if (pick < 62) cmd = CMD_RAW;
            else if (pick < 81) cmd = CMD_SET_DRY;
            else                cmd = CMD_SET_WET;
            ch = CHAN_BITS'($urandom_range(0, NUM_CHANNELS - 1));
            pick = $urandom_range(0, 9);
            if (pick == 0)      smp = ($urandom_range(0, 1) != 0) ? 10'd1023 : 10'd0;
            else if (pick == 1) smp = ($urandom_range(0, 1) != 0) ? 10'd640 : 10'd384;
            else                smp = SAMPLE_BITS'($urandom_range(0, 1023));
            pct = PCT_BITS'(($urandom_range(0, 7) == 0) ? $urandom_range(101, 127)
                                                        : $urandom_range(0, 100));
            send_request(cmd, ch, smp, pct);
            sent = sent + 1;
         end
         if (!paused && sent >= RANDOM_ITEMS / 2) begin
            drain_responses();
            paused = 1'b1;
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
         if (gap > 0) begin
            req_tvalid = 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      drain_responses();
      repeat (40) @(posedge clock);

      if (fail_count == 0 && pending == 0)
         $display("two_point_moisture_calibration verification clean");
      else
         $display("two_point_moisture_calibration verification failed");
      $finish;
   end

endmodule
